### rtl/stxcov_pkg.sv
// ============================================================================
// stxcov_pkg
// Shared types and codes of the Stirling cross-covariance core: transaction
// structs, command and register codes, and the sequencer states.
// ============================================================================
`default_nettype none

package stxcov_pkg;

    // Command codes of an input transaction
    localparam logic [1:0] CMD_LOAD_X  = 2'd0;
    localparam logic [1:0] CMD_LOAD_Y  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_PAIRS   = 2'd0;
    localparam logic [1:0] CFG_ROWS_X  = 2'd1;
    localparam logic [1:0] CFG_ROWS_Y  = 2'd2;
    localparam logic [1:0] CFG_INV_SCL = 2'd3;

    // Configuration reset values
    localparam logic [2:0]  RST_PAIRS   = 3'd4;
    localparam logic [2:0]  RST_ROWS_X  = 3'd4;
    localparam logic [2:0]  RST_ROWS_Y  = 3'd4;
    localparam logic [31:0] RST_INV_SCL = 32'd5461;

    // Input transaction
    typedef struct packed {
        logic [1:0]         cmd;
        logic [3:0]         point_index;
        logic [1:0]         element_row;
        logic signed [31:0] element_value;
    } item_t;

    // Result transaction
    typedef struct packed {
        logic [1:0]         result_row;
        logic [1:0]         result_col;
        logic signed [31:0] cov_value;
        logic               saturated;
        logic               last;
    } result_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_NEAR,
        ST_RD_FAR,
        ST_DIFF,
        ST_MUL,
        ST_ACC,
        ST_SC_LO,
        ST_SC_LO_ADD,
        ST_SC_MID,
        ST_SC_MID_ADD,
        ST_SC_TOP,
        ST_SC_TOP_ADD,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

### rtl/stirling_cross_covariance_core.sv
// ============================================================================
// stirling_cross_covariance_core
// Cross-covariance of two sets of first-order Stirling sigma points, built
// around one shared 33x33 signed multiplier under a small sequencer.
// ============================================================================
//
// Usage:
//   Input transactions are taken at a clock edge with start high and busy
//   low. Load X / load Y transactions write one point element into the X or
//   Y point memory; busy stays low, so loads stream at
//   one per cycle. Out-of-range loads and the unused command are dropped.
//   A compute transaction raises busy and walks the stored points: per
//   entry, each point pair passes through two memory reads, difference,
//   multiply and accumulate, and the scaling by inv_four_h_sq then runs
//   three partial products through the same multiplier, each followed by
//   an add, and a saturation step. Pairs and entries are worked one after
//   another: the shared multiplier and the single read port of each point
//   memory leave no room for overlap.
//   Each entry is shown for one cycle with result_strobe high, row by row,
//   column fastest; the final entry carries last and appears in the cycle
//   busy falls. The receiver cannot stall; results are never held.
//   Reset clears the sequencer and restores the configuration registers;
//   point memories are not cleared and must be written before use.
//   Configuration writes take effect at once and are meant for idle time.
//
`default_nettype none

module stirling_cross_covariance_core
    import stxcov_pkg::*;
#(
    parameter int MAX_DIM_X = 4,
    parameter int MAX_DIM_Y = 4,
    parameter int MAX_PAIRS = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // command channel
    input  wire logic        start,
    output logic             busy,
    input  wire item_t       item,
    // result channel
    output logic             result_strobe,
    output result_t          result,
    // configuration port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    // ------------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------------
    localparam int NUM_POINTS = 2 * MAX_PAIRS + 1;
    localparam int X_DEPTH    = NUM_POINTS * MAX_DIM_X;
    localparam int Y_DEPTH    = NUM_POINTS * MAX_DIM_Y;
    localparam int XA_W       = (X_DEPTH > 1) ? $clog2(X_DEPTH) : 1;
    localparam int YA_W       = (Y_DEPTH > 1) ? $clog2(Y_DEPTH) : 1;
    localparam int PT_W       = $clog2(NUM_POINTS);
    localparam int PAIR_W     = $clog2(MAX_PAIRS + 1);
    localparam int DX_W       = $clog2(MAX_DIM_X + 1);
    localparam int DY_W       = $clog2(MAX_DIM_Y + 1);
    localparam int RX_W       = (MAX_DIM_X > 1) ? $clog2(MAX_DIM_X) : 1;
    localparam int RY_W       = (MAX_DIM_Y > 1) ? $clog2(MAX_DIM_Y) : 1;
    localparam int XF_W       = XA_W + 4;
    localparam int YF_W       = YA_W + 4;
    localparam int OP_W       = 33;
    localparam int MUL_W      = 2 * OP_W;
    localparam int ACC_W      = 65 + $clog2(MAX_PAIRS);
    localparam int SCL_W      = ACC_W + 1;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    state_t                    state_reg, state_next;
    logic [2:0]                pairs_reg;
    logic [2:0]                rows_x_reg;
    logic [2:0]                rows_y_reg;
    logic [31:0]               inv_scl_reg;
    logic [PAIR_W-1:0]         i_reg, i_next;
    logic [RX_W-1:0]           r_reg, r_next;
    logic [RY_W-1:0]           c_reg, c_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [SCL_W-1:0]   scl_reg, scl_next;
    logic signed [MUL_W-1:0]   prod_reg;
    logic signed [OP_W-1:0]    dx_reg;
    logic signed [OP_W-1:0]    dy_reg;
    logic [31:0]               near_x_reg;
    logic [31:0]               near_y_reg;
    logic [31:0]               x_rdata_reg;
    logic [31:0]               y_rdata_reg;
    logic                      strobe_reg, strobe_next;
    result_t                   result_reg, result_next;

    logic [31:0]               x_mem [X_DEPTH];
    logic [31:0]               y_mem [Y_DEPTH];

    // ------------------------------------------------------------------------
    // Combinational signals
    // ------------------------------------------------------------------------
    logic                      accept;
    logic [PAIR_W-1:0]         n_use;
    logic [DX_W-1:0]           dimx_use;
    logic [DY_W-1:0]           dimy_use;
    logic                      pair_last;
    logic                      r_last;
    logic                      c_last;
    logic [PT_W-1:0]           pt_sel;
    logic [XF_W-1:0]           x_raddr_full;
    logic [YF_W-1:0]           y_raddr_full;
    logic [XF_W-1:0]           x_waddr_full;
    logic [YF_W-1:0]           y_waddr_full;
    logic                      x_we;
    logic                      y_we;
    logic signed [OP_W-1:0]    mul_a;
    logic signed [OP_W-1:0]    mul_b;
    logic signed [MUL_W-1:0]   mul_prod;
    logic signed [OP_W-1:0]    k_op;
    logic                      sat_hi;
    logic                      sat_lo;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    // ------------------------------------------------------------------------
    // Clamp the size registers to the supported range
    // ------------------------------------------------------------------------
    always_comb
    begin
        if (pairs_reg == 3'd0)
            n_use = PAIR_W'(1);
        else if (32'(pairs_reg) > MAX_PAIRS)
            n_use = PAIR_W'(MAX_PAIRS);
        else
            n_use = PAIR_W'(pairs_reg);

        if (rows_x_reg == 3'd0)
            dimx_use = DX_W'(1);
        else if (32'(rows_x_reg) > MAX_DIM_X)
            dimx_use = DX_W'(MAX_DIM_X);
        else
            dimx_use = DX_W'(rows_x_reg);

        if (rows_y_reg == 3'd0)
            dimy_use = DY_W'(1);
        else if (32'(rows_y_reg) > MAX_DIM_Y)
            dimy_use = DY_W'(MAX_DIM_Y);
        else
            dimy_use = DY_W'(rows_y_reg);
    end

    assign pair_last = (i_reg == n_use);
    assign r_last    = ((DX_W'(r_reg) + DX_W'(1)) == dimx_use);
    assign c_last    = ((DY_W'(c_reg) + DY_W'(1)) == dimy_use);

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pairs_reg   <= RST_PAIRS;
            rows_x_reg  <= RST_ROWS_X;
            rows_y_reg  <= RST_ROWS_Y;
            inv_scl_reg <= RST_INV_SCL;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PAIRS:   pairs_reg   <= cfg_data[2:0];
                CFG_ROWS_X:  rows_x_reg  <= cfg_data[2:0];
                CFG_ROWS_Y:  rows_y_reg  <= cfg_data[2:0];
                CFG_INV_SCL: inv_scl_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Point memories: write on load transactions, registered read
    // ------------------------------------------------------------------------
    assign x_waddr_full = XF_W'(item.point_index) * XF_W'(MAX_DIM_X)
                        + XF_W'(item.element_row);
    assign y_waddr_full = YF_W'(item.point_index) * YF_W'(MAX_DIM_Y)
                        + YF_W'(item.element_row);

    assign x_we = accept && (item.cmd == CMD_LOAD_X)
               && (32'(item.point_index) < NUM_POINTS)
               && (32'(item.element_row) < MAX_DIM_X);
    assign y_we = accept && (item.cmd == CMD_LOAD_Y)
               && (32'(item.point_index) < NUM_POINTS)
               && (32'(item.element_row) < MAX_DIM_Y);

    // near point i in the first read cycle, far point i+n after it
    assign pt_sel = (state_reg == ST_RD_NEAR) ? PT_W'(i_reg)
                                              : PT_W'(i_reg) + PT_W'(n_use);

    assign x_raddr_full = XF_W'(pt_sel) * XF_W'(MAX_DIM_X) + XF_W'(r_reg);
    assign y_raddr_full = YF_W'(pt_sel) * YF_W'(MAX_DIM_Y) + YF_W'(c_reg);

    always_ff @(posedge clk)
    begin
        if (x_we)
            x_mem[x_waddr_full[XA_W-1:0]] <= item.element_value;
        x_rdata_reg <= x_mem[x_raddr_full[XA_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (y_we)
            y_mem[y_waddr_full[YA_W-1:0]] <= item.element_value;
        y_rdata_reg <= y_mem[y_raddr_full[YA_W-1:0]];
    end

    // ------------------------------------------------------------------------
    // Shared multiplier: point differences, then the three scale limbs
    // ------------------------------------------------------------------------
    assign k_op = $signed({1'b0, inv_scl_reg});

    always_comb
    begin
        case (state_reg)
            ST_SC_LO:
            begin
                mul_a = $signed({1'b0, acc_reg[31:0]});
                mul_b = k_op;
            end
            ST_SC_MID:
            begin
                mul_a = $signed({1'b0, acc_reg[63:32]});
                mul_b = k_op;
            end
            ST_SC_TOP:
            begin
                mul_a = OP_W'($signed(acc_reg[ACC_W-1:64]));
                mul_b = k_op;
            end
            default:
            begin
                mul_a = dx_reg;
                mul_b = dy_reg;
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;

    // ------------------------------------------------------------------------
    // Datapath registers without reset
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_prod;
        acc_reg  <= acc_next;
        scl_reg  <= scl_next;
        if (state_reg == ST_RD_FAR)
        begin
            near_x_reg <= x_rdata_reg;
            near_y_reg <= y_rdata_reg;
        end
        if (state_reg == ST_DIFF)
        begin
            dx_reg <= $signed({near_x_reg[31], near_x_reg})
                    - $signed({x_rdata_reg[31], x_rdata_reg});
            dy_reg <= $signed({near_y_reg[31], near_y_reg})
                    - $signed({y_rdata_reg[31], y_rdata_reg});
        end
        result_reg <= result_next;
    end

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            i_reg      <= '0;
            r_reg      <= '0;
            c_reg      <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            i_reg      <= i_next;
            r_reg      <= r_next;
            c_reg      <= c_next;
            strobe_reg <= strobe_next;
        end
    end

    // ------------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.cmd == CMD_COMPUTE))
                    state_next = ST_RD_NEAR;
            end
            ST_RD_NEAR:    state_next = ST_RD_FAR;
            ST_RD_FAR:     state_next = ST_DIFF;
            ST_DIFF:       state_next = ST_MUL;
            ST_MUL:        state_next = ST_ACC;
            ST_ACC:        state_next = pair_last ? ST_SC_LO : ST_RD_NEAR;
            ST_SC_LO:      state_next = ST_SC_LO_ADD;
            ST_SC_LO_ADD:  state_next = ST_SC_MID;
            ST_SC_MID:     state_next = ST_SC_MID_ADD;
            ST_SC_MID_ADD: state_next = ST_SC_TOP;
            ST_SC_TOP:     state_next = ST_SC_TOP_ADD;
            ST_SC_TOP_ADD: state_next = ST_EMIT;
            ST_EMIT:       state_next = (r_last && c_last) ? ST_IDLE : ST_RD_NEAR;
            default:       state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // Saturate the scaled sum: in range when bits 31 and up all agree
    // ------------------------------------------------------------------------
    assign sat_hi = !scl_reg[SCL_W-1] && (|scl_reg[SCL_W-2:31]);
    assign sat_lo =  scl_reg[SCL_W-1] && !(&scl_reg[SCL_W-2:31]);

    // ------------------------------------------------------------------------
    // Counters, accumulators and result
    // ------------------------------------------------------------------------
    always_comb
    begin
        i_next      = i_reg;
        r_next      = r_reg;
        c_next      = c_reg;
        acc_next    = acc_reg;
        scl_next    = scl_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                // start the matrix at entry (0,0), pair 1
                if (accept && (item.cmd == CMD_COMPUTE))
                begin
                    i_next   = PAIR_W'(1);
                    r_next   = '0;
                    c_next   = '0;
                    acc_next = '0;
                end
            end
            ST_ACC:
            begin
                acc_next = acc_reg + ACC_W'(prod_reg);
                if (!pair_last)
                    i_next = i_reg + PAIR_W'(1);
            end
            ST_SC_LO_ADD:
            begin
                // floor of the low limb product over 2^32
                scl_next = SCL_W'(prod_reg[63:32]);
            end
            ST_SC_MID_ADD:
            begin
                scl_next = scl_reg + SCL_W'(prod_reg);
            end
            ST_SC_TOP_ADD:
            begin
                scl_next = scl_reg + (SCL_W'(prod_reg) <<< 32);
            end
            ST_EMIT:
            begin
                strobe_next           = 1'b1;
                result_next.result_row = 2'(r_reg);
                result_next.result_col = 2'(c_reg);
                result_next.saturated  = sat_hi || sat_lo;
                result_next.last       = r_last && c_last;
                if (sat_hi)
                    result_next.cov_value = 32'sh7FFF_FFFF;
                else if (sat_lo)
                    result_next.cov_value = 32'sh8000_0000;
                else
                    result_next.cov_value = $signed(scl_reg[31:0]);
                // advance to the next entry, column fastest
                i_next   = PAIR_W'(1);
                acc_next = '0;
                if (c_last)
                begin
                    c_next = '0;
                    r_next = r_reg + RX_W'(1);
                end
                else
                begin
                    c_next = c_reg + RY_W'(1);
                end
            end
            default: ;
        endcase
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_strobe_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(state_reg == ST_EMIT))
        else $error("result strobe without an emit cycle");

    a_last_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.last) |-> !busy)
        else $error("sequencer still busy after the final entry");

    a_pair_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC) |-> ((i_reg != '0) && (i_reg <= n_use)))
        else $error("pair counter out of range");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.saturated) |->
            ((result.cov_value == 32'sh7FFF_FFFF) ||
             (result.cov_value == 32'sh8000_0000)))
        else $error("saturated entry not at a range limit");

endmodule

`default_nettype wire
